// ----- rtl/core/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg : shared types and constants for the bounded deque with search
// Field widths, stream packing, action and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // request fields
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;

    // result fields
    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 5;
    localparam int RES_W    = STATUS_W + POS_W + COUNT_W;

    // packed stream widths, rounded up to whole bytes
    localparam int IN_TDATA_W  = ((ACTION_W + 2 * VALUE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

    localparam int ACTION_LSB = 0;
    localparam int VALUE_LSB  = ACTION_W;
    localparam int REPL_LSB   = ACTION_W + VALUE_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_FIND       = 3'd4,
        ACT_EDIT       = 3'd5
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // result word: status, position, count from the lowest bit up
    function automatic logic [RES_W-1:0] pack_result(
        input t_status          status,
        input logic [POS_W-1:0] position,
        input logic [COUNT_W-1:0] count
    );
        return {count, position, status};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bdq_ram.sv -----
// ----------------------------------------------------------------------------
// bdq_ram : generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bounded_deque_with_search_top.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_with_search_top : ring-buffer deque with linear search
// Push/pop at either end, find first match, overwrite first match.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis stream: one transfer per request, packed as
//   action, value (key on find/edit) and replacement. Each request yields
//   exactly one result transfer on m_axis: status, 1-based match position
//   and entry count after the request.
//   Push and pop finish in the acceptance cycle; the result is registered and
//   then moves through the output register to m_axis. Find and edit read the
//   entries one per cycle through the single read port of the entry RAM,
//   front first, and stop at the first match or after the last held entry.
//   The next request is taken once the previous result has moved into the
//   output register, so no new request is taken while a scan runs.
//   Reset (synchronous, active low) empties the deque; the RAM content is
//   not cleared, since only written entries are ever read.
//   If the sink stalls, the result waits in the output register, one more
//   result is held behind it, and s_axis_tready drops until space frees.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_search_top #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // request stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: action[2:0], value[34:3], replacement[66:35], zero fill
    input  wire logic [bdq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // result stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata: status[1:0], position[6:2], entry_count[11:7], zero fill
    output logic      [bdq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    import bdq_pkg::*;

    localparam int IW = $clog2(DEPTH);      // ring slot index
    localparam int CW = $clog2(DEPTH + 1);  // count 0..DEPTH
    localparam int SW = CW + 1;             // front + count before wrap

    localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
    localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } t_state;

    // truncate or zero-extend a count to the 5-bit result field
    function automatic logic [COUNT_W-1:0] narrow5(input logic [CW-1:0] v);
        logic [CW+COUNT_W-1:0] t;
        t = {{COUNT_W{1'b0}}, v};
        return t[COUNT_W-1:0];
    endfunction

    // request fields
    logic [ACTION_W-1:0]           w_action;
    logic [VALUE_W-1:0]            w_value;
    logic [VALUE_W-1:0]            w_repl;
    logic [DATA_WIDTH+VALUE_W-1:0] w_value_ext;
    logic [DATA_WIDTH+VALUE_W-1:0] w_repl_ext;
    logic [DATA_WIDTH-1:0]         w_key;
    logic [DATA_WIDTH-1:0]         w_repl_data;

    assign w_action    = s_axis_tdata[ACTION_LSB +: ACTION_W];
    assign w_value     = s_axis_tdata[VALUE_LSB +: VALUE_W];
    assign w_repl      = s_axis_tdata[REPL_LSB +: VALUE_W];
    assign w_value_ext = {{DATA_WIDTH{1'b0}}, w_value};
    assign w_repl_ext  = {{DATA_WIDTH{1'b0}}, w_repl};
    assign w_key       = w_value_ext[DATA_WIDTH-1:0];
    assign w_repl_data = w_repl_ext[DATA_WIDTH-1:0];

    // state and registers
    t_state              r_state,     n_state;
    logic [IW-1:0]       r_front,     n_front;
    logic [CW-1:0]       r_count,     n_count;
    logic [DATA_WIDTH-1:0] r_key,     n_key;
    logic [DATA_WIDTH-1:0] r_repl,    n_repl;
    logic                r_is_edit,   n_is_edit;
    logic [CW-1:0]       r_issue,     n_issue;     // entries read so far
    logic [IW-1:0]       r_rd_slot,   n_rd_slot;   // slot of next read
    logic                r_cmp_valid, n_cmp_valid; // RAM data is live
    logic [CW-1:0]       r_cmp_k,     n_cmp_k;     // offset of live data
    logic [IW-1:0]       r_cmp_slot,  n_cmp_slot;
    logic                r_res_pend,  n_res_pend;  // result waiting for output
    logic [RES_W-1:0]    r_res,       n_res;
    logic                r_out_valid, n_out_valid;
    logic [RES_W-1:0]    r_out_data,  n_out_data;

    // RAM port signals
    logic                  w_wr_en;
    logic [IW-1:0]         w_wr_addr;
    logic [DATA_WIDTH-1:0] w_wr_data;
    logic                  w_rd_en;
    logic [DATA_WIDTH-1:0] w_rd_data;

    // ring arithmetic
    logic [IW-1:0] w_front_dec;
    logic [IW-1:0] w_front_inc;
    logic [SW-1:0] w_back_sum;
    logic [IW-1:0] w_back_slot;
    logic [IW-1:0] w_rd_inc;

    assign w_front_dec = (r_front == '0) ? LAST_SLOT : r_front - IW'(1);
    assign w_front_inc = (r_front == LAST_SLOT) ? '0 : r_front + IW'(1);
    assign w_back_sum  = SW'(r_front) + SW'(r_count);
    assign w_back_slot = (w_back_sum >= DEPTH_S) ? IW'(w_back_sum - DEPTH_S)
                                                 : IW'(w_back_sum);
    assign w_rd_inc    = (r_rd_slot == LAST_SLOT) ? '0 : r_rd_slot + IW'(1);

    assign s_axis_tready = (r_state == S_IDLE) && !r_res_pend;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, r_out_data};

    always_comb begin
        t_status       st;
        logic [CW-1:0] pos;

        st          = ST_OK;
        pos         = '0;
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_key       = r_key;
        n_repl      = r_repl;
        n_is_edit   = r_is_edit;
        n_issue     = r_issue;
        n_rd_slot   = r_rd_slot;
        n_cmp_valid = r_cmp_valid;
        n_cmp_k     = r_cmp_k;
        n_cmp_slot  = r_cmp_slot;
        n_res_pend  = r_res_pend;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_wr_en     = 1'b0;
        w_wr_addr   = w_back_slot;
        w_wr_data   = w_key;
        w_rd_en     = 1'b0;

        // output register and the one result held behind it
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (r_res_pend && (!r_out_valid || m_axis_tready)) begin
            n_out_valid = 1'b1;
            n_out_data  = r_res;
            n_res_pend  = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_res_pend = 1'b1;
                    unique case (w_action) inside
                        ACT_PUSH_FRONT: begin
                            if (r_count == DEPTH_C) begin
                                st = ST_FULL;
                            end else begin
                                w_wr_en   = 1'b1;
                                w_wr_addr = w_front_dec;
                                n_front   = w_front_dec;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        ACT_PUSH_BACK: begin
                            if (r_count == DEPTH_C) begin
                                st = ST_FULL;
                            end else begin
                                w_wr_en = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        ACT_POP_FRONT: begin
                            if (r_count == '0) begin
                                st = ST_EMPTY;
                            end else begin
                                n_front = w_front_inc;
                                n_count = r_count - CW'(1);
                            end
                        end
                        ACT_POP_BACK: begin
                            if (r_count == '0) begin
                                st = ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        ACT_FIND, ACT_EDIT: begin
                            if (r_count == '0) begin
                                st = ST_EMPTY;
                            end else begin
                                n_res_pend  = 1'b0;
                                n_state     = S_SCAN;
                                n_key       = w_key;
                                n_repl      = w_repl_data;
                                n_is_edit   = (w_action == ACT_EDIT);
                                n_issue     = '0;
                                n_rd_slot   = r_front;
                                n_cmp_valid = 1'b0;
                            end
                        end
                        default: begin
                            // unused codes: no effect
                        end
                    endcase
                    n_res = pack_result(st, narrow5(pos), narrow5(n_count));
                end
            end

            S_SCAN: begin
                // issue the next read while the previous data is compared
                w_rd_en     = (r_issue != r_count);
                n_cmp_valid = w_rd_en;
                n_cmp_k     = r_issue;
                n_cmp_slot  = r_rd_slot;
                if (w_rd_en) begin
                    n_issue   = r_issue + CW'(1);
                    n_rd_slot = w_rd_inc;
                end

                if (r_cmp_valid && (w_rd_data == r_key)) begin
                    pos        = r_cmp_k + CW'(1);
                    w_wr_en    = r_is_edit;
                    w_wr_addr  = r_cmp_slot;
                    w_wr_data  = r_repl;
                    n_state    = S_IDLE;
                    n_res_pend = 1'b1;
                    n_res      = pack_result(ST_OK, narrow5(pos), narrow5(r_count));
                end else if (r_cmp_valid && (r_cmp_k == r_count - CW'(1))) begin
                    n_state    = S_IDLE;
                    n_res_pend = 1'b1;
                    n_res      = pack_result(ST_NOT_FOUND, narrow5(pos),
                                             narrow5(r_count));
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_cmp_valid <= 1'b0;
            r_res_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_cmp_valid <= n_cmp_valid;
            r_res_pend  <= n_res_pend;
            r_out_valid <= n_out_valid;
        end
        // payload, no reset
        r_key      <= n_key;
        r_repl     <= n_repl;
        r_is_edit  <= n_is_edit;
        r_issue    <= n_issue;
        r_rd_slot  <= n_rd_slot;
        r_cmp_k    <= n_cmp_k;
        r_cmp_slot <= n_cmp_slot;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    bdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_slot),
        .o_rd_data (w_rd_data)
    );

endmodule

`default_nettype wire

// ----- rtl/core/bdq_chk.sv -----
// ----------------------------------------------------------------------------
// bdq_chk : port-level checks for the bounded deque with search
// Result consistency and output stall behaviour, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_chk #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic [bdq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [bdq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    import bdq_pkg::*;

    logic [STATUS_W-1:0] w_status;
    logic [POS_W-1:0]    w_pos;
    logic [COUNT_W-1:0]  w_cnt;
    logic                w_req;

    assign w_status = m_axis_tdata[STATUS_W-1:0];
    assign w_pos    = m_axis_tdata[STATUS_W +: POS_W];
    assign w_cnt    = m_axis_tdata[STATUS_W + POS_W +: COUNT_W];
    assign w_req    = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '0);

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // count never beyond capacity (while the 5-bit field can show it)
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !w_req |-> (DEPTH > 31) || (int'(w_cnt) <= DEPTH))
        else $error("entry count above capacity");

    // full refusal only at capacity
    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_status == ST_FULL) |-> w_cnt == COUNT_W'(DEPTH))
        else $error("full status with spare room");

    // empty refusal shows an empty store and no position
    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_status == ST_EMPTY) |-> (w_cnt == '0) && (w_pos == '0))
        else $error("empty status with entries held");

    // a position is reported only on success
    a_pos_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_pos != '0) |-> w_status == ST_OK)
        else $error("position on a failed request");

endmodule

bind bounded_deque_with_search_top bdq_chk #(
    .DEPTH (DEPTH)
) u_bdq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for the bounded deque with search
// Drives request transfers into s_axis and keeps its own ring-buffer copy of
// the deque to predict every result. Each result transfer on m_axis is
// compared field by field with the oldest outstanding prediction. A short
// directed table comes first (empty and full refusals, extreme values, first
// match on edit, spare action codes). It is followed by random episodes: fill
// to full, drain past empty, and mixed traffic. These run under three idling
// mixes, each with a full drain pause and all but the second with a long sink stall.
// ----------------------------------------------------------------------------

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bdq_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int RANDOM_ITEMS   = 700;
    localparam int SINK_HOLD_CYC  = 300;   // long sink stall, enough to back up s_axis
    localparam int STALL_LIMIT    = 4000;  // cycles with no transfer on either side
    localparam int MAX_REPORTS    = 10;
    localparam int FILL_W         = IN_TDATA_W - REPL_LSB - VALUE_W;

    // action codes the block treats as no-ops
    localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

    // result word, lowest field last
    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [POS_W-1:0]    position;
        logic [STATUS_W-1:0] status;
    } t_result;

    // one row of the directed table; reps > 1 pushes val, val+1, ...
    typedef struct {
        logic [ACTION_W-1:0] act;
        logic [VALUE_W-1:0]  val;
        logic [VALUE_W-1:0]  rep;
        int                  reps;
        bit                  typed;   // expected result given below, not predicted
        t_status             st;
        int                  pos;
        int                  cnt;
    } t_step;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // tdata: action[2:0], value[34:3], replacement[66:35], zero fill
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // tdata: status[1:0], position[6:2], entry_count[11:7], zero fill
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    bounded_deque_with_search_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // Deque shadow: ring of DEPTH words, head slot and fill level
    // ------------------------------------------------------------------------
    logic [VALUE_W-1:0] deque_mem [DEPTH];
    int                 head_slot  = 0;
    int                 fill_level = 0;

    t_result            result_q [$];   // predicted results, oldest first

    // run bookkeeping
    int mismatch_count = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int hits           = 0;
    int misses         = 0;
    int full_refusals  = 0;
    int empty_refusals = 0;
    int peak_fill      = 0;

    // idling controls; src is read only by the stimulus process
    int src_idle_pct   = 24;
    int sink_idle_pct  = 85;
    logic sink_hold_tog = 1'b0;   // each toggle asks the sink for one long stall

    // ------------------------------------------------------------------------
    // Directed table: refusals on empty, spare codes, extremes, first match,
    // fill to full, refusals on full, match at the last position.
    // ------------------------------------------------------------------------
    t_step plan [18] = '{
        '{ACT_POP_FRONT,  32'h0000_0000, 32'h0000_0000,  1, 1'b1, ST_EMPTY,      0,  0},
        '{ACT_POP_BACK,   32'h0000_0000, 32'h0000_0000,  1, 1'b1, ST_EMPTY,      0,  0},
        '{ACT_FIND,       32'h0000_0000, 32'h0000_0000,  1, 1'b1, ST_EMPTY,      0,  0},
        '{ACT_EDIT,       32'h0000_0000, 32'h0000_0000,  1, 1'b1, ST_EMPTY,      0,  0},
        '{ACT_SPARE_A,    32'hFFFF_FFFF, 32'hFFFF_FFFF,  1, 1'b1, ST_OK,         0,  0},
        '{ACT_PUSH_BACK,  32'h7FFF_FFFF, 32'h0000_0000,  1, 1'b1, ST_OK,         0,  1},
        '{ACT_PUSH_FRONT, 32'h8000_0000, 32'h0000_0000,  1, 1'b1, ST_OK,         0,  2},
        '{ACT_PUSH_BACK,  32'h8000_0000, 32'h0000_0000,  1, 1'b1, ST_OK,         0,  3},
        '{ACT_PUSH_FRONT, 32'h0000_0000, 32'h0000_0000,  1, 1'b1, ST_OK,         0,  4},
        // two copies of the minimum held: only the one nearer the front changes
        '{ACT_EDIT,       32'h8000_0000, 32'hFFFF_FFFF,  1, 1'b1, ST_OK,         2,  4},
        '{ACT_FIND,       32'h8000_0000, 32'h0000_0000,  1, 1'b1, ST_OK,         4,  4},
        '{ACT_FIND,       32'h1234_5678, 32'h0000_0000,  1, 1'b1, ST_NOT_FOUND,  0,  4},
        '{ACT_PUSH_BACK,  32'h0000_0100, 32'h0000_0000, 11, 1'b0, ST_OK,         0,  0},
        '{ACT_PUSH_FRONT, 32'hFFFF_FFFF, 32'h0000_0000,  1, 1'b1, ST_OK,         0, 16},
        '{ACT_PUSH_BACK,  32'h0000_0001, 32'h0000_0000,  1, 1'b1, ST_FULL,       0, 16},
        '{ACT_PUSH_FRONT, 32'h0000_0001, 32'h0000_0000,  1, 1'b1, ST_FULL,       0, 16},
        '{ACT_FIND,       32'h0000_010A, 32'h0000_0000,  1, 1'b1, ST_OK,        16, 16},
        '{ACT_EDIT,       32'hFFFF_FFFF, 32'h0000_0000,  1, 1'b1, ST_OK,         1, 16}
    };

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Shadow update for one accepted request; returns the expected result
    // ------------------------------------------------------------------------
    function automatic t_result apply_request(input logic [ACTION_W-1:0] act,
                                              input logic [VALUE_W-1:0]  key,
                                              input logic [VALUE_W-1:0]  repl);
        t_result r;
        int      hit;
        r.status   = ST_OK;
        r.position = '0;
        hit        = -1;
        case (act) inside
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                if (fill_level >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (act == ACT_PUSH_FRONT) begin
                        head_slot            = (head_slot + DEPTH - 1) % DEPTH;
                        deque_mem[head_slot] = key;
                    end else begin
                        deque_mem[(head_slot + fill_level) % DEPTH] = key;
                    end
                    fill_level++;
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
                if (fill_level == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (act == ACT_POP_FRONT)
                        head_slot = (head_slot + 1) % DEPTH;
                    fill_level--;
                end
            end
            ACT_FIND, ACT_EDIT: begin
                if (fill_level == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // front-first scan, stop at the first match
                    for (int k = 0; k < fill_level && hit < 0; k++)
                        if (deque_mem[(head_slot + k) % DEPTH] == key)
                            hit = k;
                    if (hit < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        r.position = POS_W'(hit + 1);
                        if (act == ACT_EDIT)
                            deque_mem[(head_slot + hit) % DEPTH] = repl;
                    end
                end
            end
            default: ;   // spare codes: no change
        endcase
        r.count = COUNT_W'(fill_level);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Source side: offer one request, hold it until the transfer happens.
    // tvalid is left high on return; the next call (or a pause) sets it in
    // the same step, so it never sees two assignments there.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [ACTION_W-1:0] act,
                             input logic [VALUE_W-1:0]  key,
                             input logic [VALUE_W-1:0]  repl,
                             input bit                  typed,
                             input t_result             typed_res);
        t_result predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{FILL_W{1'b0}}, repl, key, act};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);

        predicted = apply_request(act, key, repl);
        result_q.push_back(typed ? typed_res : predicted);
        items_sent++;
        case (predicted.status)
            ST_FULL:      full_refusals++;
            ST_EMPTY:     empty_refusals++;
            ST_NOT_FOUND: misses++;
            default:      if (predicted.position != 0) hits++;
        endcase
        if (fill_level > peak_fill)
            peak_fill = fill_level;
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain_outstanding();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (result_q.size() != 0);
    endtask

    // small pool of values so that finds and edits hit and duplicates occur
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'h0000_0001;
            5:       return 32'hAAAA_AAAA;
            6:       return 32'h5555_5555;
            default: return $urandom();
        endcase
    endfunction

    // random request for a chosen action; find/edit keys mostly taken from held entries
    task automatic send_random(input logic [ACTION_W-1:0] act);
        logic [VALUE_W-1:0] key;
        logic [VALUE_W-1:0] repl;
        t_result            none;
        none = '0;
        if ((act == ACT_FIND || act == ACT_EDIT) && fill_level > 0
                && $urandom_range(0, 99) < 70)
            key = deque_mem[(head_slot + $urandom_range(0, fill_level - 1)) % DEPTH];
        else
            key = ($urandom_range(0, 1) != 0) ? pick_value() : $urandom();
        repl = ($urandom_range(0, 1) != 0) ? pick_value() : $urandom();
        send_item(act, key, repl, 1'b0, none);
    endtask

    function automatic logic [ACTION_W-1:0] either_end(input logic [ACTION_W-1:0] front,
                                                       input logic [ACTION_W-1:0] back);
        return ($urandom_range(0, 1) != 0) ? front : back;
    endfunction

    // one burst of traffic: fill to full, drain past empty, or a random mix
    task automatic run_episode();
        int kind;
        int n;
        int pick;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            while (fill_level < DEPTH)
                send_random(either_end(ACT_PUSH_FRONT, ACT_PUSH_BACK));
            n = $urandom_range(1, 2);
            repeat (n) send_random(either_end(ACT_PUSH_FRONT, ACT_PUSH_BACK));
        end else if (kind < 4) begin
            while (fill_level > 0)
                send_random(either_end(ACT_POP_FRONT, ACT_POP_BACK));
            send_random(either_end(ACT_POP_FRONT, ACT_POP_BACK));
        end else begin
            n = $urandom_range(6, 20);
            repeat (n) begin
                pick = $urandom_range(0, 99);
                if (pick < 30)      send_random(either_end(ACT_PUSH_FRONT, ACT_PUSH_BACK));
                else if (pick < 55) send_random(either_end(ACT_POP_FRONT, ACT_POP_BACK));
                else if (pick < 75) send_random(ACT_FIND);
                else if (pick < 95) send_random(ACT_EDIT);
                else                send_random(either_end(ACT_SPARE_A, ACT_SPARE_B));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sink side: take result transfers, check them, then choose tready.
    // A toggle of sink_hold_tog starts one long stall counted here.
    // ------------------------------------------------------------------------
    task automatic log_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch on result %0d: %s expected %0d, got %0d",
                     $realtime, results_seen, what, want, got);
    endtask

    task automatic check_result(input logic [OUT_TDATA_W-1:0] word);
        t_result got;
        t_result want;
        got = t_result'(word[RES_W-1:0]);
        results_seen++;
        if (result_q.size() == 0) begin
            log_mismatch("unrequested result, status", -1, got.status);
        end else begin
            want = result_q.pop_front();
            if (got.status != want.status)
                log_mismatch("status", want.status, got.status);
            if (got.position != want.position)
                log_mismatch("position", want.position, got.position);
            if (got.count != want.count)
                log_mismatch("entry_count", want.count, got.count);
        end
    endtask

    initial begin : sink
        int   hold_left;
        logic seen_tog;
        hold_left = 0;
        seen_tog  = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
                check_result(m_axis_tdata);
            if (sink_hold_tog != seen_tog) begin
                seen_tog  = sink_hold_tog;
                hold_left = SINK_HOLD_CYC;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without a transfer on either side ends the run
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready === 1'b1)
                    || (m_axis_tvalid === 1'b1 && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("[%0t] timeout: no transfer for %0d cycles, %0d results outstanding",
                         $realtime, STALL_LIMIT, result_q.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_result typed_res;
        int      target;
        bit      held;
        bit      paused;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, sender 24 % idle, sink 85 % idle
        foreach (plan[i]) begin
            for (int k = 0; k < plan[i].reps; k++) begin
                typed_res.status   = plan[i].st;
                typed_res.position = POS_W'(plan[i].pos);
                typed_res.count    = COUNT_W'(plan[i].cnt);
                send_item(plan[i].act, plan[i].val + VALUE_W'(k), plan[i].rep,
                          plan[i].typed, typed_res);
            end
        end

        // random part in three idling mixes
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 24; sink_idle_pct <= 85; end
                1: begin src_idle_pct = 85; sink_idle_pct <= 24; end
                default: begin src_idle_pct = 0; sink_idle_pct <= 0; end
            endcase
            target = items_sent + RANDOM_ITEMS / 3;
            held   = 1'b0;
            paused = 1'b0;
            while (items_sent < target) begin
                run_episode();
                // long sink stall while requests keep coming: s_axis backs up
                if (!held && phase != 1 && items_sent >= target - 150) begin
                    sink_hold_tog <= ~sink_hold_tog;
                    held = 1'b1;
                end
                // sender pause until the block has answered everything
                if (!paused && items_sent >= target - 80) begin
                    drain_outstanding();
                    paused = 1'b1;
                end
            end
        end

        drain_outstanding();
        // keep watching the result stream for stray results
        repeat (DEPTH + 8) @(posedge i_clk);

        $display("Covered %0d requests: %0d hits on find/edit, %0d not found, peak fill %0d",
                 items_sent, hits, misses, peak_fill);
        $display("Refusals: %0d on full store, %0d on empty store; %0d mismatches",
                 full_refusals, empty_refusals, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/bdq_pkg.sv
rtl/core/bdq_ram.sv
rtl/core/bounded_deque_with_search_top.sv
rtl/core/bdq_chk.sv
test/tb_top.sv
